FILE: src/slack_aware_queue_dispatcher_assert.svh
// assertion macros for the dispatcher checker
`ifndef SLACK_AWARE_QUEUE_DISPATCHER_ASSERT_SVH
`define SLACK_AWARE_QUEUE_DISPATCHER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SQD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define SQD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sqd_pkg.sv
// shared types, codes and helpers of the slack-aware queue dispatcher
package sqd_pkg;

	localparam int unsigned NUM_ENGINES       = 3;
	localparam int unsigned MODELS_DEFAULT    = 16;
	localparam int unsigned QUEUE_MAX_DEFAULT = 255;
	localparam int unsigned FIFO_DEPTH        = 2;

	localparam int unsigned TIME_W = 24;
	localparam logic [TIME_W-1:0] ONE_MS = 24'd256;

	// 9*avg + latency fits in 28 bits
	localparam int unsigned SUM_W       = 28;
	localparam int unsigned RECIP_W     = 29;
	localparam int unsigned RECIP_SHIFT = 32;
	// floor(2^32 / 10): the quotient comes out low by at most one
	localparam logic [RECIP_W-1:0] RECIP_TEN = 29'd429496729;
	localparam int unsigned QUO_W = SUM_W + RECIP_W - RECIP_SHIFT;

	localparam logic [1:0] CMD_DISPATCH = 2'd0;
	localparam logic [1:0] CMD_DEQUEUE  = 2'd1;
	localparam logic [1:0] CMD_REPORT   = 2'd2;

	localparam logic [1:0] ENG_CPU  = 2'd0;
	localparam logic [1:0] ENG_GPU  = 2'd1;
	localparam logic [1:0] ENG_DSP  = 2'd2;
	localparam logic [1:0] ENG_NONE = 2'd3;

	localparam logic [2:0] POL_CPU    = 3'd0;
	localparam logic [2:0] POL_GPU    = 3'd1;
	localparam logic [2:0] POL_DSP    = 3'd2;
	localparam logic [2:0] POL_RANDOM = 3'd3;
	localparam logic [2:0] POL_SHORT  = 3'd4;
	localparam logic [2:0] POL_SLACK  = 3'd5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_ENGINE = 2'd1,
		ST_EMPTY     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_DISPATCH,
		OP_DEQUEUE,
		OP_REPORT,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [3:0]        model_index;
		logic [2:0]        avail_mask;
		logic [TIME_W-1:0] slack_ms;
		logic [7:0]        random_value;
		logic [1:0]        engine;
		logic [TIME_W-1:0] latency_ms;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_flags_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_READ,
		BS_SLACK_MUL,
		BS_SLACK_CMP,
		BS_SUM,
		BS_MUL,
		BS_DIV,
		BS_DONE
	} back_state_t;

	// byte mod 3 by reciprocal: 171/512 is exact enough for 8-bit values
	function automatic logic [1:0] mod3(input logic [7:0] v);
		logic [15:0] p;
		logic [6:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd171;
		q = p[15:9];
		r = v - ((8'(q) << 1) + 8'(q));
		return r[1:0];
	endfunction

endpackage

FILE: src/slack_aware_queue_dispatcher.sv
// top level of the slack-aware queue dispatcher
// Each request, dequeue or latency report gives one result. The front part
// takes a request every cycle while its two-entry queue has room; the back part
// works through them one at a time on a single sequencer. A dequeue, a request
// under a fixed, random or shortest-queue policy, and a rejected request pass
// through a read state and a done state (read the model's latency row, decide,
// hand the result to the output register while the next request is read). A
// latency report adds the 9*avg+latency sum, the reciprocal multiply and the
// correction step of the divide by ten. A slack-aware request walks the
// engines, one multiply of queue length by average latency and one compare
// for each engine walked. The latency averages sit in a memory of one row per
// model with a valid bit per row, so there is no clearing pass after reset. The
// user must write the policy register over the cfg channel, which is always
// ready, only while no request is in flight; the block does not enforce this.
module slack_aware_queue_dispatcher #(
	parameter int unsigned MODELS    = sqd_pkg::MODELS_DEFAULT,
	parameter int unsigned QUEUE_MAX = sqd_pkg::QUEUE_MAX_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 cmd,
	input  logic [3:0]                 model_index,
	input  logic [2:0]                 avail_mask,
	input  logic [sqd_pkg::TIME_W-1:0] slack_ms,
	input  logic [7:0]                 random_value,
	input  logic [1:0]                 engine,
	input  logic [sqd_pkg::TIME_W-1:0] latency_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 target_engine,
	output logic [1:0]                 status,
	output logic [7:0]                 queue_length_after
);
	import sqd_pkg::*;

	logic         policy_q;
	logic [2:0]   policy_val_q;
	logic         push;
	logic         pop;
	item_t        push_item;
	item_t        head;
	queue_flags_t flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_val_q <= POL_CPU;
			policy_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			policy_val_q <= cfg_data;
			policy_q     <= 1'b1;
		end
	end

	sqd_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.model_index  (model_index),
		.avail_mask   (avail_mask),
		.slack_ms     (slack_ms),
		.random_value (random_value),
		.engine       (engine),
		.latency_ms   (latency_ms),
		.flags        (flags),
		.push         (push),
		.push_item    (push_item)
	);

	sqd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.flags     (flags)
	);

	sqd_back #(
		.MODELS    (MODELS),
		.QUEUE_MAX (QUEUE_MAX)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.policy             (policy_q ? policy_val_q : POL_CPU),
		.head               (head),
		.flags              (flags),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.target_engine      (target_engine),
		.status             (status),
		.queue_length_after (queue_length_after)
	);

endmodule

FILE: src/sqd_queue.sv
// short request queue between the front and back parts
module sqd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sqd_pkg::item_t       push_item,
	input  logic                 pop,
	output sqd_pkg::item_t       head,
	output sqd_pkg::queue_flags_t flags
);
	import sqd_pkg::*;

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t            entries_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign flags.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign flags.empty = (count_q == '0);
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: src/sqd_front.sv
// front part: takes requests and sorts them into operation classes
module sqd_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [3:0]                  model_index,
	input  logic [2:0]                  avail_mask,
	input  logic [sqd_pkg::TIME_W-1:0]  slack_ms,
	input  logic [7:0]                  random_value,
	input  logic [1:0]                  engine,
	input  logic [sqd_pkg::TIME_W-1:0]  latency_ms,
	input  sqd_pkg::queue_flags_t       flags,
	output logic                        push,
	output sqd_pkg::item_t              push_item
);
	import sqd_pkg::*;

	op_t op;

	// requests that change nothing and report no engine are marked as rejects here
	always_comb begin
		case (cmd)
			CMD_DISPATCH: op = (avail_mask == '0) ? OP_REJECT : OP_DISPATCH;
			CMD_DEQUEUE:  op = (engine == ENG_NONE) ? OP_REJECT : OP_DEQUEUE;
			CMD_REPORT:   op = (engine == ENG_NONE) ? OP_REJECT : OP_REPORT;
			default:      op = OP_NOP;
		endcase
	end

	assign in_ready = !flags.full;
	assign push     = in_valid && in_ready;

	assign push_item.op           = op;
	assign push_item.model_index  = model_index;
	assign push_item.avail_mask   = avail_mask;
	assign push_item.slack_ms     = slack_ms;
	assign push_item.random_value = random_value;
	assign push_item.engine       = engine;
	assign push_item.latency_ms   = latency_ms;

endmodule

FILE: src/sqd_back.sv
// back part: engine choice, queue counters, latency averages and result register
module sqd_back #(
	parameter int unsigned MODELS    = sqd_pkg::MODELS_DEFAULT,
	parameter int unsigned QUEUE_MAX = sqd_pkg::QUEUE_MAX_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            policy,
	input  sqd_pkg::item_t        head,
	input  sqd_pkg::queue_flags_t flags,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            target_engine,
	output logic [1:0]            status,
	output logic [7:0]            queue_length_after
);
	import sqd_pkg::*;

	localparam int unsigned QW     = $clog2(QUEUE_MAX + 1);
	localparam int unsigned MW     = (MODELS > 1) ? $clog2(MODELS) : 1;
	localparam int unsigned ROW_W  = NUM_ENGINES * TIME_W;
	localparam int unsigned PROD_W = QW + TIME_W;

	back_state_t state_q, state_d;

	item_t             cur_q;
	logic [MW-1:0]     row_addr_q;
	logic              row_ok_q;
	logic [ROW_W-1:0]  rd_row_q;
	logic [ROW_W-1:0]  mem_q [MODELS];
	logic [MODELS-1:0] row_valid_q;
	logic [QW-1:0]     qlen_q [NUM_ENGINES];
	logic [PROD_W-1:0] prod_q;
	logic [1:0]        eng_idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [QUO_W-1:0]  quo_q;
	logic [1:0]        res_tgt_q;
	status_t           res_status_q;
	logic [7:0]        res_len_q;
	logic              out_valid_q;
	logic [1:0]        out_tgt_q;
	logic [1:0]        out_status_q;
	logic [7:0]        out_len_q;

	logic [MW-1:0]       row_of [16];
	logic [MW-1:0]       head_row;
	logic [TIME_W-1:0]   avg [NUM_ENGINES];
	logic [TIME_W-1:0]   avg_sel;
	logic                slot_free;
	logic                hit;
	logic [1:0]          lowest_eng;
	logic [1:0]          fixed_eng;
	logic [1:0]          rnd_eng;
	logic [1:0]          short_eng;
	logic [QW-1:0]       short_len;
	logic                short_found;
	logic [1:0]          rnd_k;
	logic [1:0]          rnd_count;
	logic [1:0]          rnd_j;
	logic                rnd_found;
	logic [1:0]          disp_eng;
	logic [1:0]          disp_target;
	logic [QW-1:0]       disp_len;
	logic [SUM_W+RECIP_W-1:0] div_prod;
	logic [SUM_W-1:0]    div_rem;
	logic [QUO_W-1:0]    div_quo;
	logic [ROW_W-1:0]    mem_wdata;

	logic          decide;
	logic          load_out;
	logic          mem_we;
	logic          q_we;
	logic [1:0]    q_eng;
	logic [QW-1:0] q_new;
	logic [1:0]    dec_tgt;
	status_t       dec_status;
	logic [7:0]    dec_len;

	function automatic logic [7:0] shown(input logic [QW-1:0] n);
		return (32'(n) > 32'd255) ? 8'hFF : 8'(n);
	endfunction

	// model index folded onto the rows, a small constant table
	for (genvar m = 0; m < 16; m++) begin : g_row_of
		assign row_of[m] = MW'(m % MODELS);
	end

	assign head_row  = row_of[head.model_index];
	assign slot_free = !out_valid_q || out_ready;

	// rows never written read as 1.0 ms
	always_comb begin
		for (int e = 0; e < NUM_ENGINES; e++)
			avg[e] = row_ok_q ? rd_row_q[e*TIME_W +: TIME_W] : ONE_MS;
	end

	assign avg_sel = avg[cur_q.engine];
	assign hit     = cur_q.avail_mask[eng_idx_q] && (prod_q <= PROD_W'(cur_q.slack_ms));

	// lowest available engine and fixed policies
	always_comb begin
		if (cur_q.avail_mask[0])
			lowest_eng = ENG_CPU;
		else if (cur_q.avail_mask[1])
			lowest_eng = ENG_GPU;
		else
			lowest_eng = cur_q.avail_mask[2] ? ENG_DSP : ENG_CPU;
		fixed_eng = cur_q.avail_mask[policy[1:0]] ? policy[1:0] : lowest_eng;
	end

	// shortest queue, ties to the higher engine
	always_comb begin
		short_eng   = lowest_eng;
		short_len   = qlen_q[lowest_eng];
		short_found = 1'b0;
		for (int e = 0; e < NUM_ENGINES; e++) begin
			if (cur_q.avail_mask[e] && (!short_found || qlen_q[e] <= short_len)) begin
				short_eng   = 2'(e);
				short_len   = qlen_q[e];
				short_found = 1'b1;
			end
		end
	end

	// random: k-th available engine, k = value mod count
	always_comb begin
		rnd_count = 2'(cur_q.avail_mask[0]) + 2'(cur_q.avail_mask[1])
			+ 2'(cur_q.avail_mask[2]);
		case (rnd_count)
			2'd3:    rnd_k = mod3(cur_q.random_value);
			2'd2:    rnd_k = {1'b0, cur_q.random_value[0]};
			default: rnd_k = 2'd0;
		endcase
		rnd_eng   = lowest_eng;
		rnd_j     = rnd_k;
		rnd_found = 1'b0;
		for (int e = 0; e < NUM_ENGINES; e++) begin
			if (cur_q.avail_mask[e] && !rnd_found) begin
				if (rnd_j == 2'd0) begin
					rnd_eng   = 2'(e);
					rnd_found = 1'b1;
				end else begin
					rnd_j = rnd_j - 2'd1;
				end
			end
		end
	end

	always_comb begin
		if (policy inside {POL_CPU, POL_GPU, POL_DSP})
			disp_eng = fixed_eng;
		else if (policy == POL_RANDOM)
			disp_eng = rnd_eng;
		else
			disp_eng = short_eng;
	end

	// slack walk falls back to shortest queue after the cpu
	always_comb begin
		if (state_q == BS_SLACK_CMP)
			disp_target = hit ? eng_idx_q : short_eng;
		else
			disp_target = disp_eng;
		disp_len = (qlen_q[disp_target] < QW'(QUEUE_MAX)) ?
			qlen_q[disp_target] + 1'b1 : qlen_q[disp_target];
	end

	// divide by ten: reciprocal product, then one correction step
	assign div_prod   = sum_q * RECIP_TEN;
	assign div_rem    = sum_q - ((SUM_W'(quo_q) << 3) + (SUM_W'(quo_q) << 1));
	assign div_quo    = (div_rem >= SUM_W'(10)) ? quo_q + 1'b1 : quo_q;

	always_comb begin
		for (int e = 0; e < NUM_ENGINES; e++)
			mem_wdata[e*TIME_W +: TIME_W] = (2'(e) == cur_q.engine) ?
				div_quo[TIME_W-1:0] : avg[e];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!flags.empty)
					state_d = BS_READ;
			end
			BS_READ: begin
				case (cur_q.op)
					OP_DISPATCH: state_d = (policy == POL_SLACK) ? BS_SLACK_MUL : BS_DONE;
					OP_REPORT:   state_d = BS_SUM;
					default:     state_d = BS_DONE;
				endcase
			end
			BS_SLACK_MUL: state_d = BS_SLACK_CMP;
			BS_SLACK_CMP: begin
				if (hit || eng_idx_q == ENG_CPU)
					state_d = BS_DONE;
				else
					state_d = BS_SLACK_MUL;
			end
			BS_SUM: state_d = BS_MUL;
			BS_MUL: state_d = BS_DIV;
			BS_DIV: state_d = BS_DONE;
			BS_DONE: begin
				if (slot_free)
					state_d = flags.empty ? BS_IDLE : BS_READ;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		pop        = 1'b0;
		load_out   = 1'b0;
		decide     = 1'b0;
		mem_we     = 1'b0;
		q_we       = 1'b0;
		q_eng      = cur_q.engine;
		q_new      = disp_len;
		dec_tgt    = ENG_CPU;
		dec_status = ST_OK;
		dec_len    = 8'd0;
		case (state_q)
			BS_IDLE: pop = !flags.empty;
			BS_READ: begin
				case (cur_q.op)
					OP_DISPATCH: begin
						if (policy != POL_SLACK) begin
							decide  = 1'b1;
							q_we    = 1'b1;
							q_eng   = disp_target;
							dec_tgt = disp_target;
							dec_len = shown(disp_len);
						end
					end
					OP_DEQUEUE: begin
						decide  = 1'b1;
						dec_tgt = cur_q.engine;
						if (qlen_q[cur_q.engine] == '0) begin
							dec_status = ST_EMPTY;
						end else begin
							q_we    = 1'b1;
							q_new   = qlen_q[cur_q.engine] - 1'b1;
							dec_len = shown(q_new);
						end
					end
					OP_REPORT: ;
					OP_REJECT: begin
						decide     = 1'b1;
						dec_status = ST_NO_ENGINE;
					end
					default: decide = 1'b1;
				endcase
			end
			BS_SLACK_CMP: begin
				if (hit || eng_idx_q == ENG_CPU) begin
					decide  = 1'b1;
					q_we    = 1'b1;
					q_eng   = disp_target;
					dec_tgt = disp_target;
					dec_len = shown(disp_len);
				end
			end
			BS_DIV: begin
				decide  = 1'b1;
				mem_we  = 1'b1;
				dec_tgt = cur_q.engine;
				dec_len = shown(qlen_q[cur_q.engine]);
			end
			BS_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					pop      = !flags.empty;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			out_valid_q <= 1'b0;
			row_valid_q <= '0;
			for (int e = 0; e < NUM_ENGINES; e++)
				qlen_q[e] <= '0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (mem_we)
				row_valid_q[row_addr_q] <= 1'b1;
			if (q_we)
				qlen_q[q_eng] <= q_new;
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= head;
			row_addr_q <= head_row;
			row_ok_q   <= row_valid_q[head_row];
			rd_row_q   <= mem_q[head_row];
		end
		if (mem_we)
			mem_q[row_addr_q] <= mem_wdata;
		if (state_q == BS_READ)
			eng_idx_q <= ENG_DSP;
		else if (state_q == BS_SLACK_CMP)
			eng_idx_q <= eng_idx_q - 2'd1;
		if (state_q == BS_SLACK_MUL)
			prod_q <= PROD_W'(qlen_q[eng_idx_q]) * PROD_W'(avg[eng_idx_q]);
		if (state_q == BS_SUM)
			sum_q <= (SUM_W'(avg_sel) << 3) + SUM_W'(avg_sel) + SUM_W'(cur_q.latency_ms);
		if (state_q == BS_MUL)
			quo_q <= div_prod[SUM_W+RECIP_W-1:RECIP_SHIFT];
		if (decide) begin
			res_tgt_q    <= dec_tgt;
			res_status_q <= dec_status;
			res_len_q    <= dec_len;
		end
		if (load_out) begin
			out_tgt_q    <= res_tgt_q;
			out_status_q <= res_status_q;
			out_len_q    <= res_len_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign target_engine      = out_tgt_q;
	assign status             = out_status_q;
	assign queue_length_after = out_len_q;

endmodule

FILE: src/sqd_checker.sv
// port-level checks on the dispatcher results, bound to the top level
module sqd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] target_engine,
	input logic [1:0] status,
	input logic [7:0] queue_length_after
);
	import sqd_pkg::*;

	`include "slack_aware_queue_dispatcher_assert.svh"

	// a stalled result holds
	`SQD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(target_engine) && $stable(status) && $stable(queue_length_after), "result changed while stalled")

	// a rejected request reports cpu and an empty length
	`SQD_ASSERT_IMP(a_reject_zero, out_valid && status == ST_NO_ENGINE, target_engine == ENG_CPU && queue_length_after == 8'd0, "rejected request with non-zero fields")

	// an empty dequeue names a real engine and length zero
	`SQD_ASSERT_IMP(a_empty_zero, out_valid && status == ST_EMPTY, target_engine != ENG_NONE && queue_length_after == 8'd0, "empty dequeue with bad fields")

	`SQD_ASSERT_IMP(a_ok_engine, out_valid && status == ST_OK, target_engine != ENG_NONE, "accepted request on no engine")

endmodule

bind slack_aware_queue_dispatcher sqd_checker u_sqd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.target_engine      (target_engine),
	.status             (status),
	.queue_length_after (queue_length_after)
);
